/* hdl/sbd_pkg.sv */
// shared widths and register map of the solid block detector
package sbd_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 9;
  localparam int WS_W       = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 3'd0;

  localparam logic [WS_W-1:0] WINDOW_SIZE_RESET = 6'd1;

endpackage

/* hdl/sbd_run_mem.sv */
// column run memory with per-entry valid bits and a registered read
module sbd_run_mem #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 6,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      // entries not written since the last clear read as zero
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/solid_block_detector.sv */
// solid block detector: one pixel per cycle, one column-run memory read and write per pixel
// result: registered in the output register when stage one fires on the last item of an image
// throughput: one item per cycle, set by the single read and write of the run memory
// stalls only while a result waits in the output register and another one is due
// reset: synchronous, clears positions, flags and all column valid bits
// window size register resets to one; no clearing pass over the memory
module solid_block_detector
  import sbd_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WIN    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic [DIM_W-1:0]      in_img_width,
  input  logic [DIM_W-1:0]      in_img_height,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_changed,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int WW  = $clog2(MAX_WIN + 1);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RPW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  typedef struct packed {
    logic          empty;
    logic          first;
    logic          last_row;
    logic          last_img;
    logic          pix_nz;
    logic [PW-1:0] col;
    logic [WW-1:0] win_w;
    logic [WW-1:0] win_h;
  } s1_t;

  // configuration
  logic [WS_W-1:0] ws_r;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_WINDOW_SIZE);
  assign cfg_prdata = (cfg_paddr == REG_WINDOW_SIZE) ? CFG_DATA_W'(ws_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WINDOW_SIZE_RESET;
    end else if (cfg_wr) begin
      ws_r <= cfg_pwdata[WS_W-1:0];
    end
  end

  // stage 0: position tracking and memory read
  logic [PW-1:0]  col_pos_r;
  logic [RPW-1:0] row_pos_r;
  logic           accept;
  logic [CW-1:0]  w_c;
  logic [HW-1:0]  h_c;
  logic [31:0]    win32;
  logic [31:0]    win_w32;
  logic [31:0]    win_h32;
  logic           empty0;
  logic           last_row0;
  logic           last_img0;
  s1_t            s0;

  // stage 1: column run update
  s1_t            s1_r;
  logic           s1_vld_r;
  logic           s1_fire;
  logic           s1_res;
  logic           fwd_r;
  logic           zap_r;
  logic [WW-1:0]  fwd_run_r;
  logic [WW-1:0]  rd_data;
  logic [WW-1:0]  prev_run;
  logic [WW:0]    run_inc;
  logic [WW-1:0]  run_new;
  logic           full;
  logic [WW-1:0]  rr_prev;
  logic [WW:0]    rr_inc;
  logic [WW-1:0]  rr_new;
  logic           hit;
  logic [WW-1:0]  row_run_r;
  logic           found_r;

  logic           out_vld_r;
  logic           out_changed_r;

  always_comb begin
    empty0 = (in_img_width == '0) || (in_img_height == '0);
    w_c = (32'(in_img_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(in_img_width);
    h_c = (32'(in_img_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(in_img_height);
    if (ws_r == '0) begin
      win32 = 32'd1;
    end else if (32'(ws_r) > MAX_WIN) begin
      win32 = MAX_WIN;
    end else begin
      win32 = 32'(ws_r);
    end
    win_w32   = (win32 < 32'(w_c)) ? win32 : 32'(w_c);
    win_h32   = (win32 < 32'(h_c)) ? win32 : 32'(h_c);
    last_row0 = (32'(col_pos_r) + 32'd1) >= 32'(w_c);
    last_img0 = last_row0 && ((32'(row_pos_r) + 32'd1) >= 32'(h_c));

    s0.empty    = empty0;
    s0.first    = (col_pos_r == '0);
    s0.last_row = last_row0;
    s0.last_img = last_img0;
    s0.pix_nz   = (in_pixel != '0);
    s0.col      = col_pos_r;
    s0.win_w    = win_w32[WW-1:0];
    s0.win_h    = win_h32[WW-1:0];
  end

  assign s1_res   = s1_r.empty || s1_r.last_img;
  assign s1_fire  = s1_vld_r && (!s1_res || !out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (accept) begin
      if (empty0 || last_img0) begin
        col_pos_r <= '0;
        row_pos_r <= '0;
      end else if (last_row0) begin
        col_pos_r <= '0;
        row_pos_r <= row_pos_r + 1'b1;
      end else begin
        col_pos_r <= col_pos_r + 1'b1;
      end
    end
  end

  sbd_run_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (WW),
    .ADDR_W (PW)
  ) u_run_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (s1_fire && s1_res),
    .wr_en   (s1_fire && !s1_r.empty),
    .wr_addr (s1_r.col),
    .wr_data (run_new),
    .rd_en   (accept && !empty0),
    .rd_addr (col_pos_r),
    .rd_data (rd_data)
  );

  always_comb begin
    // the read in flight misses a write or a clear done at the same edge
    if (zap_r) begin
      prev_run = '0;
    end else if (fwd_r) begin
      prev_run = fwd_run_r;
    end else begin
      prev_run = rd_data;
    end
    run_inc = {1'b0, prev_run} + 1'b1;
    if (!s1_r.pix_nz) begin
      run_new = '0;
    end else if (run_inc > {1'b0, s1_r.win_h}) begin
      run_new = s1_r.win_h;
    end else begin
      run_new = run_inc[WW-1:0];
    end
    full    = (run_new >= s1_r.win_h);
    rr_prev = s1_r.first ? '0 : row_run_r;
    rr_inc  = {1'b0, rr_prev} + 1'b1;
    if (!full) begin
      rr_new = '0;
    end else if (rr_inc > {1'b0, s1_r.win_w}) begin
      rr_new = s1_r.win_w;
    end else begin
      rr_new = rr_inc[WW-1:0];
    end
    hit = (rr_new >= s1_r.win_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
      zap_r    <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
      zap_r    <= s1_fire && s1_res;
      fwd_r    <= s1_fire && !s1_res && (s1_r.col == col_pos_r);
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r      <= s0;
      fwd_run_r <= run_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_run_r <= '0;
      found_r   <= 1'b0;
    end else if (s1_fire) begin
      if (s1_res) begin
        row_run_r <= '0;
        found_r   <= 1'b0;
      end else begin
        row_run_r <= s1_r.last_row ? '0 : rr_new;
        found_r   <= found_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire && s1_res) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_res) begin
      out_changed_r <= !s1_r.empty && (found_r || hit);
    end
  end

  assign out_valid   = out_vld_r;
  assign out_changed = out_changed_r;

  // forwarding and clearing of the in-flight read exclude each other
  a_fwd_zap: assert property (@(posedge clk) disable iff (!rst_n) !(fwd_r && zap_r))
    else $error("forward and clear both set on the pending read");

  // a finished image always lands in the output register
  a_res_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_res) |=> out_vld_r)
    else $error("result lost on its way to the output register");

  // column run never exceeds the vertical window; empty items read nothing
  a_run_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_r.empty) |-> (run_new <= s1_r.win_h))
    else $error("column run above window height");

  // a stalled result holds the pipeline
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_res && out_vld_r && out_stall) |=> (s1_vld_r && $stable(s1_r)))
    else $error("stage one moved while the output was blocked");

  // column position stays inside the run memory
  a_col_rng: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_pos_r) < MAX_WIDTH)
    else $error("column position out of range");

endmodule
